FILE: design/clp_pkg.sv
package clp_pkg;

    // Gain format: unsigned Q0.16 with one extra bit so that 1.0 fits.
    localparam int GAIN_BITS  = 16;
    localparam int GAIN_WIDTH = GAIN_BITS + 1;
    localparam logic [GAIN_WIDTH-1:0] GAIN_ONE = GAIN_WIDTH'(1) << GAIN_BITS;

    // Rounding constant added to every gain product before the low bits drop.
    localparam logic [GAIN_WIDTH-1:0] PRODUCT_ROUND = GAIN_WIDTH'(1) << (GAIN_BITS - 1);

    // Configuration port layout.
    localparam int PADDR_WIDTH = 3;
    localparam int PDATA_WIDTH = 32;
    localparam int ORDER_WIDTH = 2;
    localparam logic REG_GAIN  = 1'b0;
    localparam logic REG_ORDER = 1'b1;
    localparam logic [ORDER_WIDTH-1:0] ORDER_RESET = 2'd1;
    localparam logic [ORDER_WIDTH-1:0] ORDER_TWO   = 2'd2;
    localparam logic [ORDER_WIDTH-1:0] ORDER_THREE = 2'd3;

    // Cascade layout.
    localparam int NUM_STAGES = 3;
    // Distance in cycles between the starts of two neighboring stages.
    localparam int STAGE_OFFSET = GAIN_BITS + 1;

    typedef enum logic [1:0] {
        CTRL_IDLE,
        CTRL_RUN,
        CTRL_WRITE
    } ctrl_state_t;

    // Control from the sequencer to one bit-serial stage.
    typedef struct packed {
        logic start;
        logic clear;
    } stage_ctl_t;

endpackage

FILE: design/clp_in_if.sv
interface clp_in_if #(
    parameter int SAMPLE_WIDTH = 16
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           clear_state;

    modport source (output valid, output sample_in, output clear_state, input ready);
    modport sink (input valid, input sample_in, input clear_state, output ready);
endinterface

FILE: design/clp_out_if.sv
interface clp_out_if #(
    parameter int SAMPLE_WIDTH = 16
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

FILE: design/cascaded_first_order_lowpass_unit.sv
// Channel    Direction  Transfer when         Payload
// raw        in         valid && ready        sample_in, clear_state
// filtered   out        valid && ready        sample_out
// APB        in         psel&penable&pwrite   filter_gain at 0x0, filter_order at 0x4
//
// A new sample is taken only while the sequencer is idle, that is, once the result
// of the sample before it has been written to the output register.
// The time per sample is set by the three bit-serial stages: each handles one bit
// of its state per cycle, and each stage starts while the one before it is still
// running, so that it takes in the new state bits as they are produced.
// Reset zeroes the three stage states and loads gain 1.0 and order 1.
// A finished result waits in the output register; a new sample is already
// taken while it waits, and the sequencer holds only if that register is full.
module cascaded_first_order_lowpass_unit #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    clp_in_if.sink                           raw,
    clp_out_if.source                        filtered,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [clp_pkg::PADDR_WIDTH-1:0]  paddr,
    input  logic [clp_pkg::PDATA_WIDTH-1:0]  pwdata,
    output logic [clp_pkg::PDATA_WIDTH-1:0]  prdata,
    output logic                             pready
);
    import clp_pkg::*;

    localparam int STATE_WIDTH = SAMPLE_WIDTH + FRACTION_BITS;
    localparam int RUN_CYCLES  = STATE_WIDTH + GAIN_BITS;
    localparam int SEQ_LAST    = (NUM_STAGES - 1) * STAGE_OFFSET - 1 + RUN_CYCLES;
    localparam int SEQ_WIDTH   = $clog2(SEQ_LAST + 1);
    localparam logic [STATE_WIDTH:0] OUT_ROUND = (STATE_WIDTH + 1)'(1) << (FRACTION_BITS - 1);

    ctrl_state_t                    ctrl_state_reg;
    ctrl_state_t                    ctrl_state_next;
    logic [SEQ_WIDTH-1:0]           seq_cnt_reg;
    logic [GAIN_WIDTH-1:0]          gain_reg;
    logic [ORDER_WIDTH-1:0]         order_reg;
    logic [STATE_WIDTH-1:0]         x_reg;
    logic                           clear_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_out_reg;
    logic                           out_valid_reg;
    logic [GAIN_WIDTH-1:0]          gain_eff;
    logic                           in_xfer;
    logic                           out_xfer;
    logic                           cfg_write;
    logic                           load_out;
    stage_ctl_t                     stage_ctl [NUM_STAGES];
    logic                           stage_x [NUM_STAGES];
    logic                           stage_out [NUM_STAGES];
    logic signed [STATE_WIDTH-1:0]  stage_state [NUM_STAGES];
    logic signed [STATE_WIDTH-1:0]  sel_state;
    logic [STATE_WIDTH:0]           round_sum;

    assign in_xfer   = raw.valid && raw.ready;
    assign out_xfer  = filtered.valid && filtered.ready;
    assign cfg_write = psel && penable && pwrite;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= GAIN_ONE;
            order_reg <= ORDER_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_GAIN:  gain_reg  <= pwdata[GAIN_WIDTH-1:0];
                REG_ORDER: order_reg <= pwdata[ORDER_WIDTH-1:0];
                default:   ;
            endcase
        end
    end

    // Register readback; the port never inserts wait states.
    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            REG_GAIN:  prdata[GAIN_WIDTH-1:0]  = gain_reg;
            REG_ORDER: prdata[ORDER_WIDTH-1:0] = order_reg;
            default:   prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // A gain above 1.0 acts as 1.0.
    assign gain_eff = (gain_reg > GAIN_ONE) ? GAIN_ONE : gain_reg;

    // Sequencer next state.
    always_comb
    begin
        ctrl_state_next = ctrl_state_reg;
        unique case (ctrl_state_reg)
            CTRL_IDLE:
            begin
                if (raw.valid)
                begin
                    ctrl_state_next = CTRL_RUN;
                end
            end
            CTRL_RUN:
            begin
                if (seq_cnt_reg == SEQ_WIDTH'(SEQ_LAST))
                begin
                    ctrl_state_next = CTRL_WRITE;
                end
            end
            CTRL_WRITE:
            begin
                if (!out_valid_reg || filtered.ready)
                begin
                    ctrl_state_next = CTRL_IDLE;
                end
            end
            default: ctrl_state_next = CTRL_IDLE;
        endcase
    end

    // Sequencer outputs: stage starts are staggered so that each stage sees
    // the previous stage's new state bits as they are produced.
    always_comb
    begin
        raw.ready = 1'b0;
        load_out  = 1'b0;
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            stage_ctl[i].start = 1'b0;
            stage_ctl[i].clear = clear_reg;
        end
        stage_ctl[0].clear = raw.clear_state;
        unique case (ctrl_state_reg)
            CTRL_IDLE:
            begin
                raw.ready          = 1'b1;
                stage_ctl[0].start = raw.valid;
            end
            CTRL_RUN:
            begin
                for (int i = 1; i < NUM_STAGES; i++)
                begin
                    stage_ctl[i].start = (seq_cnt_reg == SEQ_WIDTH'(i * STAGE_OFFSET - 1));
                end
            end
            CTRL_WRITE:
            begin
                load_out = !out_valid_reg || filtered.ready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_state_reg <= CTRL_IDLE;
            seq_cnt_reg    <= '0;
        end
        else
        begin
            ctrl_state_reg <= ctrl_state_next;
            if (in_xfer)
            begin
                seq_cnt_reg <= '0;
            end
            else if (ctrl_state_reg == CTRL_RUN)
            begin
                seq_cnt_reg <= seq_cnt_reg + SEQ_WIDTH'(1);
            end
        end
    end

    // Input sample in fixed point, shifted out LSB first with sign extension.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            x_reg     <= {raw.sample_in, {FRACTION_BITS{1'b0}}};
            clear_reg <= raw.clear_state;
        end
        else
        begin
            x_reg <= {x_reg[STATE_WIDTH-1], x_reg[STATE_WIDTH-1:1]};
        end
    end

    // Cascade of bit-serial stages, each after the first fed by the one before it.
    assign stage_x[0] = x_reg[0];
    for (genvar i = 1; i < NUM_STAGES; i++)
    begin : g_chain
        assign stage_x[i] = stage_out[i-1];
    end

    for (genvar i = 0; i < NUM_STAGES; i++)
    begin : g_stage
        clp_stage_cell #(
            .STATE_WIDTH (STATE_WIDTH)
        ) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (stage_ctl[i]),
            .x_bit   (stage_x[i]),
            .gain    (gain_eff),
            .out_bit (stage_out[i]),
            .state   (stage_state[i])
        );
    end

    // Pick the stage named by the order and round it to a sample, halves up.
    always_comb
    begin
        unique case (order_reg)
            ORDER_TWO:   sel_state = stage_state[1];
            ORDER_THREE: sel_state = stage_state[2];
            default:     sel_state = stage_state[0];
        endcase
    end
    assign round_sum = {sel_state[STATE_WIDTH-1], sel_state} + OUT_ROUND;

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_xfer)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            sample_out_reg <= round_sum[STATE_WIDTH-1:FRACTION_BITS];
        end
    end

    assign filtered.valid      = out_valid_reg;
    assign filtered.sample_out = sample_out_reg;

endmodule

FILE: design/clp_stage_cell.sv
module clp_stage_cell #(
    parameter int STATE_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  clp_pkg::stage_ctl_t               ctl,
    input  logic                              x_bit,
    input  logic [clp_pkg::GAIN_WIDTH-1:0]    gain,
    output logic                              out_bit,
    output logic signed [STATE_WIDTH-1:0]     state
);
    import clp_pkg::*;

    localparam int RUN_CYCLES = STATE_WIDTH + GAIN_BITS;
    localparam int CNT_WIDTH  = $clog2(RUN_CYCLES);

    logic signed [STATE_WIDTH-1:0] state_reg;
    logic [STATE_WIDTH-1:0]        sub_reg;
    logic [GAIN_WIDTH-1:0]         prod_reg;
    logic [GAIN_WIDTH-1:0]         prod_next;
    logic [GAIN_WIDTH:0]           prod_sum;
    logic                          borrow_reg;
    logic                          borrow_next;
    logic                          carry_reg;
    logic                          carry_next;
    logic [CNT_WIDTH-1:0]          cnt_reg;
    logic                          busy_reg;
    logic                          s_bit;
    logic                          d_bit;
    logic                          p_bit;
    logic                          a_bit;
    logic                          new_bit;
    logic                          update_phase;

    // Serial subtractor: difference bit of input minus old state, LSB first.
    assign s_bit       = sub_reg[0];
    assign d_bit       = x_bit ^ s_bit ^ borrow_reg;
    assign borrow_next = (~x_bit & s_bit) | (~x_bit & borrow_reg) | (s_bit & borrow_reg);

    // Serial-parallel multiplier: one difference bit times the whole gain per cycle.
    assign prod_sum  = {1'b0, prod_reg} + (d_bit ? {1'b0, gain} : '0);
    assign p_bit     = prod_sum[0];
    assign prod_next = prod_sum[GAIN_WIDTH:1];

    // Serial adder: once the product's fraction bits are gone, add the step to the state.
    assign update_phase = (cnt_reg >= CNT_WIDTH'(GAIN_BITS));
    assign a_bit        = state_reg[0];
    assign new_bit      = a_bit ^ p_bit ^ carry_reg;
    assign carry_next   = (a_bit & p_bit) | (a_bit & carry_reg) | (p_bit & carry_reg);

    // The newest state bit sits at the top; after the run the sign bit stays there.
    assign out_bit = state_reg[STATE_WIDTH-1];
    assign state   = state_reg;

    // Stage state and run control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
        end
        else if (ctl.start)
        begin
            if (ctl.clear)
            begin
                state_reg <= '0;
            end
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            if (update_phase)
            begin
                state_reg <= {new_bit, state_reg[STATE_WIDTH-1:1]};
            end
            cnt_reg <= cnt_reg + CNT_WIDTH'(1);
            if (cnt_reg == CNT_WIDTH'(RUN_CYCLES - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Serial datapath registers.
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            sub_reg    <= ctl.clear ? '0 : state_reg;
            prod_reg   <= PRODUCT_ROUND;
            borrow_reg <= 1'b0;
            carry_reg  <= 1'b0;
        end
        else if (busy_reg)
        begin
            sub_reg    <= {sub_reg[STATE_WIDTH-1], sub_reg[STATE_WIDTH-1:1]};
            prod_reg   <= prod_next;
            borrow_reg <= borrow_next;
            if (update_phase)
            begin
                carry_reg <= carry_next;
            end
        end
    end

endmodule

FILE: design/clp_checker.sv
module clp_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [SAMPLE_WIDTH-1:0] sample_out
);

    // After a transfer in, the block stays busy and keeps its input not ready.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready ##1 !in_ready)
        else $error("input taken again too soon after a transfer");

    // A new result appears only as the sequencer returns to waiting for input.
    a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result appeared while the sequencer was still busy");

    // A result that is not taken stays, unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(sample_out)))
        else $error("stalled result changed or dropped");

endmodule

bind cascaded_first_order_lowpass_unit clp_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_clp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (raw.valid),
    .in_ready   (raw.ready),
    .out_valid  (filtered.valid),
    .out_ready  (filtered.ready),
    .sample_out (filtered.sample_out)
);
